// ----- design/prx_pkg.sv -----
// ----------------------------------------------------------------------------
// prx_pkg: shared types and constants of the printable run extractor
//
// Holds the channel word types, the configuration indexes, the character
// constants and the control word that the sequencer sends to the cell row.
// ----------------------------------------------------------------------------
package prx_pkg;

    localparam int BYTE_W     = 8;
    localparam int MIN_LEN_W  = 6;
    localparam int MAX_RUNS_W = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [BYTE_W-1:0] CHAR_TAB       = 8'd9;
    localparam logic [BYTE_W-1:0] CHAR_SPACE     = 8'd32;
    localparam logic [BYTE_W-1:0] CHAR_PRINT_LOW = 8'd32;
    localparam logic [BYTE_W-1:0] CHAR_PRINT_HI  = 8'd126;

    localparam logic [MIN_LEN_W-1:0]  MIN_LEN_RESET  = 6'd4;
    localparam logic [MAX_RUNS_W-1:0] MAX_RUNS_RESET = 8'd24;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_RUN_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RUNS       = 2'd1;

    // Input item kinds
    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_EOS  = 1'b1;

    typedef struct packed {
        logic              kind;
        logic [BYTE_W-1:0] data_byte;
    } in_word_t;

    typedef struct packed {
        logic [BYTE_W-1:0]     run_char;
        logic                  last_in_run;
        logic [MAX_RUNS_W-1:0] run_number;
    } out_word_t;

    // Control shared by every cell of the row
    typedef struct packed {
        logic              shift;
        logic              load;
        logic [BYTE_W-1:0] load_byte;
    } cell_ctl_t;

    typedef enum logic {
        ST_COLLECT,
        ST_DRAIN
    } seq_state_t;

endpackage

// ----- design/printable_run_extractor.sv -----
// A run is emitted starting in the cycle after the word that ends it is taken.
// The block takes one byte word per cycle while collecting; an emitted run
// then drains from the head cell one word per cycle while m_ready is high,
// and no input word is taken during the drain.
// Reset clears the sequencer, fill and run count and loads the default
// minimum length 4 and maximum run count 24; buffer cells are not cleared.
// ----------------------------------------------------------------------------
// printable_run_extractor: top level
//
// Collects printable byte runs in a row of shifting cells and emits runs
// that meet the minimum length, up to the configured number of runs.
// ----------------------------------------------------------------------------
module printable_run_extractor #(
    parameter int RUN_CAPACITY = 63
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  prx_pkg::in_word_t                 s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output prx_pkg::out_word_t                m_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [prx_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [prx_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int FILL_W = $clog2(RUN_CAPACITY + 1);
    localparam int IDX_W  = $clog2(RUN_CAPACITY);

    logic [prx_pkg::MIN_LEN_W-1:0]  min_len_reg;
    logic [prx_pkg::MAX_RUNS_W-1:0] max_runs_reg;

    prx_pkg::cell_ctl_t             ctl;
    logic [IDX_W-1:0]               load_idx;
    logic [prx_pkg::BYTE_W-1:0]     cell_bytes [RUN_CAPACITY];
    logic                           last_in_run;
    logic [prx_pkg::MAX_RUNS_W-1:0] run_number;

    // Configuration registers; unknown indexes are ignored
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_len_reg  <= prx_pkg::MIN_LEN_RESET;
            max_runs_reg <= prx_pkg::MAX_RUNS_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                prx_pkg::CFG_MIN_RUN_LENGTH: begin
                    min_len_reg <= cfg_data[prx_pkg::MIN_LEN_W-1:0];
                end
                prx_pkg::CFG_MAX_RUNS: begin
                    max_runs_reg <= cfg_data[prx_pkg::MAX_RUNS_W-1:0];
                end
                default: begin
                    min_len_reg <= min_len_reg;
                end
            endcase
        end
    end

    prx_ctrl #(
        .RUN_CAPACITY (RUN_CAPACITY),
        .FILL_W       (FILL_W),
        .IDX_W        (IDX_W)
    ) u_ctrl (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data         (s_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .last_in_run    (last_in_run),
        .run_number     (run_number),
        .min_run_length (min_len_reg),
        .max_runs       (max_runs_reg),
        .ctl            (ctl),
        .load_idx       (load_idx)
    );

    // Row of cells; each shifts toward the head cell
    for (genvar i = 0; i < RUN_CAPACITY; i++) begin : g_cell
        logic                       sel;
        logic [prx_pkg::BYTE_W-1:0] neighbor_byte;

        assign sel = (load_idx == IDX_W'(i));

        if (i == RUN_CAPACITY - 1) begin : g_tail
            assign neighbor_byte = '0;
        end else begin : g_body
            assign neighbor_byte = cell_bytes[i+1];
        end

        prx_cell u_cell (
            .aclk          (aclk),
            .ctl           (ctl),
            .sel           (sel),
            .neighbor_byte (neighbor_byte),
            .cell_byte     (cell_bytes[i])
        );
    end

    // Result word comes straight from the head cell
    assign m_data.run_char    = cell_bytes[0];
    assign m_data.last_in_run = last_in_run;
    assign m_data.run_number  = run_number;

endmodule

// ----- design/prx_cell.sv -----
// ----------------------------------------------------------------------------
// prx_cell: one byte cell of the run buffer row
//
// Takes a new character when selected for a load (tab stored as space) and
// otherwise takes its upper neighbor's character when the row shifts.
// ----------------------------------------------------------------------------
module prx_cell (
    input  logic                          aclk,
    input  prx_pkg::cell_ctl_t            ctl,
    input  logic                          sel,
    input  logic [prx_pkg::BYTE_W-1:0]    neighbor_byte,
    output logic [prx_pkg::BYTE_W-1:0]    cell_byte
);

    logic [prx_pkg::BYTE_W-1:0] byte_reg;
    logic [prx_pkg::BYTE_W-1:0] mapped_byte;

    // Turn a tab into a space on the way in
    assign mapped_byte = (ctl.load_byte == prx_pkg::CHAR_TAB) ? prx_pkg::CHAR_SPACE
                                                              : ctl.load_byte;

    // Load wins over shift so a waiting byte can land in the head cell
    always_ff @(posedge aclk) begin
        if (ctl.load && sel) begin
            byte_reg <= mapped_byte;
        end else if (ctl.shift) begin
            byte_reg <= neighbor_byte;
        end
    end

    assign cell_byte = byte_reg;

endmodule

// ----- design/prx_ctrl.sv -----
// ----------------------------------------------------------------------------
// prx_ctrl: run sequencer
//
// Classifies incoming words, tracks the run fill and the emitted run count,
// and drains an ended run out of the head cell one character per word.
// ----------------------------------------------------------------------------
module prx_ctrl #(
    parameter int RUN_CAPACITY = 63,
    parameter int FILL_W       = 6,
    parameter int IDX_W        = 6
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  prx_pkg::in_word_t                 s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              last_in_run,
    output logic [prx_pkg::MAX_RUNS_W-1:0]    run_number,
    input  logic [prx_pkg::MIN_LEN_W-1:0]     min_run_length,
    input  logic [prx_pkg::MAX_RUNS_W-1:0]    max_runs,
    output prx_pkg::cell_ctl_t                ctl,
    output logic [IDX_W-1:0]                  load_idx
);

    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(RUN_CAPACITY);
    localparam logic [FILL_W-1:0] FILL_ONE  = FILL_W'(1);
    localparam logic [prx_pkg::MAX_RUNS_W-1:0] RUNS_ONE = prx_pkg::MAX_RUNS_W'(1);

    prx_pkg::seq_state_t state_reg, state_next;

    logic [FILL_W-1:0]                  fill_reg, fill_next;
    logic [FILL_W-1:0]                  remain_reg, remain_next;
    logic [prx_pkg::MAX_RUNS_W-1:0]     runs_reg, runs_next;
    logic                               pend_reg, pend_next;
    logic [prx_pkg::BYTE_W-1:0]         pend_byte_reg, pend_byte_next;

    logic in_accept;
    logic printable;
    logic store_byte;
    logic run_ends;
    logic run_emit;
    logic drain_done;

    // Classify the incoming word
    assign in_accept  = s_valid && s_ready;
    assign printable  = (s_data.data_byte == prx_pkg::CHAR_TAB) ||
                        ((s_data.data_byte >= prx_pkg::CHAR_PRINT_LOW) &&
                         (s_data.data_byte <= prx_pkg::CHAR_PRINT_HI));
    assign store_byte = (s_data.kind == prx_pkg::KIND_DATA) && printable;
    assign run_ends   = (s_data.kind == prx_pkg::KIND_EOS) || !printable ||
                        (fill_reg == FILL_FULL);
    assign run_emit   = run_ends && (fill_reg != '0) &&
                        (prx_pkg::MIN_LEN_W'(fill_reg) >= min_run_length) &&
                        (runs_reg < max_runs);
    assign drain_done = m_ready && (remain_reg == FILL_ONE);

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            prx_pkg::ST_COLLECT: begin
                if (in_accept && run_emit) begin
                    state_next = prx_pkg::ST_DRAIN;
                end
            end
            prx_pkg::ST_DRAIN: begin
                if (drain_done) begin
                    state_next = prx_pkg::ST_COLLECT;
                end
            end
            default: begin
                state_next = prx_pkg::ST_COLLECT;
            end
        endcase
    end

    // Outputs and counters
    always_comb begin
        s_ready        = 1'b0;
        m_valid        = 1'b0;
        ctl.shift      = 1'b0;
        ctl.load       = 1'b0;
        ctl.load_byte  = s_data.data_byte;
        load_idx       = '0;
        fill_next      = fill_reg;
        remain_next    = remain_reg;
        runs_next      = runs_reg;
        pend_next      = pend_reg;
        pend_byte_next = pend_byte_reg;
        case (state_reg)
            prx_pkg::ST_COLLECT: begin
                s_ready = 1'b1;
                if (in_accept) begin
                    if (run_emit) begin
                        // Hold the byte that overflowed a full buffer
                        remain_next    = fill_reg;
                        pend_next      = store_byte;
                        pend_byte_next = s_data.data_byte;
                    end else if (run_ends) begin
                        // Drop the run; a printable byte starts the next one
                        ctl.load  = store_byte;
                        fill_next = store_byte ? FILL_ONE : '0;
                    end else begin
                        ctl.load  = 1'b1;
                        load_idx  = fill_reg[IDX_W-1:0];
                        fill_next = fill_reg + FILL_ONE;
                    end
                end
            end
            prx_pkg::ST_DRAIN: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    ctl.shift   = 1'b1;
                    remain_next = remain_reg - FILL_ONE;
                    if (remain_reg == FILL_ONE) begin
                        // Close the run and place any held byte in the head cell
                        runs_next     = runs_reg + RUNS_ONE;
                        ctl.load      = pend_reg;
                        ctl.load_byte = pend_byte_reg;
                        fill_next     = pend_reg ? FILL_ONE : '0;
                        pend_next     = 1'b0;
                    end
                end
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    assign last_in_run = (remain_reg == FILL_ONE);
    assign run_number  = runs_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= prx_pkg::ST_COLLECT;
            fill_reg   <= '0;
            remain_reg <= '0;
            runs_reg   <= '0;
            pend_reg   <= 1'b0;
        end else begin
            state_reg  <= state_next;
            fill_reg   <= fill_next;
            remain_reg <= remain_next;
            runs_reg   <= runs_next;
            pend_reg   <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_byte_reg <= pend_byte_next;
    end

endmodule

// ----- dv/tb_printable_run_extractor.sv -----
// ----------------------------------------------------------------------------
// tb_printable_run_extractor: self-checking bench of the printable run extractor
//
// Feeds byte and end-of-stream words through a queue-fed driver, tracks the
// run buffer and run count in a local model, and checks every emitted
// character word against the oldest predicted one. The run steps through
// several register settings and three back-pressure profiles.
// ----------------------------------------------------------------------------
module tb_printable_run_extractor;

    localparam int RUN_CAP     = 63;
    localparam int STALL_LIMIT = 2000;
    localparam int SETTLE_CYC  = 8;

    // Indexes past the register map; writes to them must be ignored
    localparam logic [prx_pkg::CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [prx_pkg::CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    logic                           aclk;
    logic                           aresetn;
    logic                           s_valid;
    logic                           s_ready;
    prx_pkg::in_word_t              s_data;
    logic                           m_valid;
    logic                           m_ready;
    prx_pkg::out_word_t             m_data;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [prx_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [prx_pkg::CFG_DATA_W-1:0] cfg_data;

    // Stimulus and expected character words
    prx_pkg::in_word_t  words_to_send[$];
    prx_pkg::out_word_t chars_due[$];
    int                 words_queued;
    int                 words_taken;
    int                 cfg_writes_taken;
    int                 stall_cycles;
    int                 n_fail;
    int                 s_idle_pct;
    int                 m_idle_pct;
    logic               s_taken;

    // Local copy of the run buffer, run count and registers
    logic [prx_pkg::BYTE_W-1:0]     run_bytes[RUN_CAP];
    int                             run_len;
    logic [prx_pkg::MAX_RUNS_W-1:0] runs_out;
    logic [prx_pkg::MIN_LEN_W-1:0]  min_len;
    logic [prx_pkg::MAX_RUNS_W-1:0] max_out;

    printable_run_extractor #(
        .RUN_CAPACITY(RUN_CAP)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    function automatic logic is_printable(logic [prx_pkg::BYTE_W-1:0] b);
        return (b == prx_pkg::CHAR_TAB) ||
               (b >= prx_pkg::CHAR_PRINT_LOW && b <= prx_pkg::CHAR_PRINT_HI);
    endfunction

    // Close the pending run: queue its characters if it qualifies, then empty it
    function void end_pending_run();
        prx_pkg::out_word_t         w;
        logic [prx_pkg::BYTE_W-1:0] ch;
        if (run_len > 0 && run_len >= int'(min_len) && runs_out < max_out) begin
            for (int i = 0; i < run_len; i++) begin
                ch = run_bytes[i];
                if (ch == prx_pkg::CHAR_TAB) begin
                    ch = prx_pkg::CHAR_SPACE;
                end
                w.run_char    = ch;
                w.last_in_run = (i == run_len - 1);
                w.run_number  = runs_out;
                chars_due.push_back(w);
            end
            runs_out = runs_out + prx_pkg::MAX_RUNS_W'(1);
        end
        run_len = 0;
    endfunction

    // Advance the local model by one accepted input word
    function void track_input_word(prx_pkg::in_word_t w);
        if (w.kind == prx_pkg::KIND_EOS || !is_printable(w.data_byte)) begin
            end_pending_run();
        end else begin
            if (run_len >= RUN_CAP) begin
                end_pending_run();
            end
            run_bytes[run_len] = w.data_byte;
            run_len++;
        end
    endfunction

    // Clock
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Input driver: hold a word until taken, then offer the next one
    always @(negedge aclk) begin
        if (aresetn) begin
            if (!s_valid || s_taken) begin
                if (words_to_send.size() != 0 && $urandom_range(99) >= s_idle_pct) begin
                    s_valid <= 1'b1;
                    s_data  <= words_to_send.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result back-pressure
    always @(negedge aclk) begin
        if (aresetn) begin
            m_ready <= ($urandom_range(99) >= m_idle_pct);
        end
    end

    // Monitor: predict on accepted inputs, check accepted results
    always @(posedge aclk) begin
        prx_pkg::out_word_t want;
        if (aresetn) begin
            s_taken = s_valid && s_ready;
            if (s_taken) begin
                track_input_word(s_data);
                words_taken++;
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    prx_pkg::CFG_MIN_RUN_LENGTH: begin
                        min_len = cfg_data[prx_pkg::MIN_LEN_W-1:0];
                    end
                    prx_pkg::CFG_MAX_RUNS: begin
                        max_out = cfg_data;
                    end
                    default: begin
                    end
                endcase
                cfg_writes_taken++;
            end
            if (m_valid && m_ready) begin
                if (chars_due.size() == 0) begin
                    $error("unexpected result word: run_char %0d last_in_run %0d run_number %0d",
                           m_data.run_char, m_data.last_in_run, m_data.run_number);
                    n_fail++;
                end else begin
                    want = chars_due.pop_front();
                    if (m_data.run_char !== want.run_char) begin
                        $error("run_char: expected %0d, got %0d", want.run_char, m_data.run_char);
                        n_fail++;
                    end
                    if (m_data.last_in_run !== want.last_in_run) begin
                        $error("last_in_run: expected %0d, got %0d",
                               want.last_in_run, m_data.last_in_run);
                        n_fail++;
                    end
                    if (m_data.run_number !== want.run_number) begin
                        $error("run_number: expected %0d, got %0d",
                               want.run_number, m_data.run_number);
                        n_fail++;
                    end
                end
            end
            if (s_taken || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    initial begin
        do begin
            @(negedge aclk);
        end while (stall_cycles < STALL_LIMIT);
        $display("printable_run_extractor regression: fail");
        $finish;
    end

    task automatic push_word(logic kind, logic [prx_pkg::BYTE_W-1:0] b);
        prx_pkg::in_word_t w;
        w.kind      = kind;
        w.data_byte = b;
        words_to_send.push_back(w);
        words_queued++;
    endtask

    task automatic push_printable();
        if ($urandom_range(9) == 0) begin
            push_word(prx_pkg::KIND_DATA, prx_pkg::CHAR_TAB);
        end else begin
            push_word(prx_pkg::KIND_DATA, 8'($urandom_range(126, 32)));
        end
    endtask

    task automatic push_terminator();
        logic [prx_pkg::BYTE_W-1:0] b;
        if ($urandom_range(3) == 0) begin
            push_word(prx_pkg::KIND_EOS, 8'($urandom_range(255)));
        end else begin
            do begin
                b = 8'($urandom_range(255));
            end while (is_printable(b));
            push_word(prx_pkg::KIND_DATA, b);
        end
    endtask

    // Queue mostly well-formed runs around the current minimum, plus noise
    task automatic queue_random_words(int n);
        int target;
        int pick;
        int len;
        target = words_queued + n;
        while (words_queued < target) begin
            pick = $urandom_range(99);
            if (pick < 10) begin
                push_word(prx_pkg::KIND_DATA, 8'($urandom_range(255)));
            end else begin
                if (pick < 55) begin
                    len = int'(min_len) - 1 + $urandom_range(2);
                end else if (pick < 90) begin
                    len = $urandom_range(12, 1);
                end else begin
                    len = $urandom_range(70, 58);
                end
                if (len < 1) begin
                    len = 1;
                end
                repeat (len) push_printable();
                push_terminator();
            end
        end
    endtask

    task automatic write_reg(logic [prx_pkg::CFG_IDX_W-1:0] idx,
                             logic [prx_pkg::CFG_DATA_W-1:0] val);
        int seen;
        seen = cfg_writes_taken;
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do begin
            @(negedge aclk);
        end while (cfg_writes_taken == seen);
        cfg_valid <= 1'b0;
    endtask

    // Wait until every word is taken and every result has come, then drain
    task automatic settle();
        while (words_taken != words_queued || chars_due.size() != 0) begin
            @(negedge aclk);
        end
        repeat (SETTLE_CYC) @(negedge aclk);
    endtask

    // Main sequence
    initial begin
        aresetn          = 1'b0;
        s_valid          = 1'b0;
        s_data           = '0;
        m_ready          = 1'b0;
        cfg_valid        = 1'b0;
        cfg_index        = prx_pkg::CFG_MIN_RUN_LENGTH;
        cfg_data         = '0;
        s_taken          = 1'b0;
        words_queued     = 0;
        words_taken      = 0;
        cfg_writes_taken = 0;
        stall_cycles     = 0;
        n_fail           = 0;
        run_len          = 0;
        runs_out         = '0;
        min_len          = prx_pkg::MIN_LEN_RESET;
        max_out          = prx_pkg::MAX_RUNS_RESET;
        s_idle_pct       = 15;
        m_idle_pct       = 84;

        repeat (9) @(negedge aclk);
        aresetn = 1'b1;

        // Directed words under the reset settings
        push_word(prx_pkg::KIND_EOS, 8'hFF);                  // empty run, data ignored
        push_word(prx_pkg::KIND_DATA, prx_pkg::CHAR_PRINT_LOW); // range edges and tabs
        push_word(prx_pkg::KIND_DATA, prx_pkg::CHAR_PRINT_HI);
        push_word(prx_pkg::KIND_DATA, prx_pkg::CHAR_TAB);
        push_word(prx_pkg::KIND_DATA, prx_pkg::CHAR_TAB);
        push_word(prx_pkg::KIND_DATA, 8'd127);                // just above printable
        push_word(prx_pkg::KIND_DATA, 8'h41);                 // three bytes: too short
        push_word(prx_pkg::KIND_DATA, 8'h42);
        push_word(prx_pkg::KIND_DATA, 8'h43);
        push_word(prx_pkg::KIND_DATA, 8'h00);
        push_word(prx_pkg::KIND_DATA, 8'd31);                 // just below printable
        push_word(prx_pkg::KIND_DATA, 8'hFF);
        push_word(prx_pkg::KIND_DATA, 8'h78);                 // flushed by end of stream
        push_word(prx_pkg::KIND_DATA, 8'h79);
        push_word(prx_pkg::KIND_DATA, 8'h7A);
        push_word(prx_pkg::KIND_DATA, 8'h77);
        push_word(prx_pkg::KIND_DATA, 8'h76);
        push_word(prx_pkg::KIND_EOS, 8'h00);
        push_word(prx_pkg::KIND_DATA, 8'h61);                 // tab inside, ended by 8 and 10
        push_word(prx_pkg::KIND_DATA, prx_pkg::CHAR_TAB);
        push_word(prx_pkg::KIND_DATA, 8'h62);
        push_word(prx_pkg::KIND_DATA, 8'h63);
        push_word(prx_pkg::KIND_DATA, 8'd8);
        push_word(prx_pkg::KIND_DATA, 8'd10);
        settle();

        write_reg(prx_pkg::CFG_MIN_RUN_LENGTH, 8'd1);
        write_reg(prx_pkg::CFG_MAX_RUNS, 8'd255);
        queue_random_words(90);
        settle();

        // Upper bits of the length write fall outside the field
        write_reg(prx_pkg::CFG_MIN_RUN_LENGTH, 8'hC5);
        queue_random_words(60);
        settle();

        s_idle_pct = 84;
        m_idle_pct = 15;
        write_reg(prx_pkg::CFG_MIN_RUN_LENGTH, 8'd63);
        write_reg(prx_pkg::CFG_MAX_RUNS, 8'd200);
        queue_random_words(70);
        settle();

        // Spare indexes leave both registers alone; minimum length of zero
        write_reg(CFG_SPARE_2, 8'($urandom_range(255)));
        write_reg(CFG_SPARE_3, 8'($urandom_range(255)));
        write_reg(prx_pkg::CFG_MIN_RUN_LENGTH, 8'h40);
        queue_random_words(60);
        settle();

        s_idle_pct = 0;
        m_idle_pct = 0;
        // Limit below the runs already emitted, then zero: nothing comes out
        write_reg(prx_pkg::CFG_MIN_RUN_LENGTH, 8'd3);
        write_reg(prx_pkg::CFG_MAX_RUNS, 8'd1);
        queue_random_words(40);
        settle();

        write_reg(prx_pkg::CFG_MAX_RUNS, 8'd0);
        queue_random_words(30);
        settle();

        write_reg(prx_pkg::CFG_MIN_RUN_LENGTH, 8'd2);
        write_reg(prx_pkg::CFG_MAX_RUNS, 8'd255);
        queue_random_words(75);
        settle();

        if (n_fail == 0) begin
            $display("printable_run_extractor regression: pass");
        end else begin
            $display("printable_run_extractor regression: fail");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
design/prx_pkg.sv
design/prx_cell.sv
design/prx_ctrl.sv
design/printable_run_extractor.sv
dv/tb_printable_run_extractor.sv
